/* hw/rtl/qedc_pkg.sv */
// shared types and constants for the quadrature encoder counter
package qedc_pkg;

    localparam int CMD_BITS    = 3;
    localparam int KEY_BITS    = 2;
    localparam int WINDOW_BITS = 16;
    localparam int TOTAL_BITS  = 16;
    localparam int IN_BYTES_W  = 8;
    localparam int OUT_BYTES_W = 24;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1000;

    localparam logic [CMD_BITS-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_FALL_A   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_FALL_B   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_FALL_BTN = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ     = 3'd4;

    localparam logic [KEY_BITS-1:0] KEY_NONE  = 2'd0;
    localparam logic [KEY_BITS-1:0] KEY_NEXT  = 2'd1;
    localparam logic [KEY_BITS-1:0] KEY_PREV  = 2'd2;
    localparam logic [KEY_BITS-1:0] KEY_ENTER = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [CMD_BITS-1:0] command;
        logic                level_a;
        logic                level_b;
    } stage_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] step_total;
        logic                  press_seen;
        logic [KEY_BITS-1:0]   nav_key;
    } result_t;

endpackage

/* hw/rtl/qedc_in_stage.sv */
// input register for encoder events
module qedc_in_stage
    import qedc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BYTES_W-1:0] s_tdata,
    input  logic                  advance,
    output stage_t                stage
);

    logic                valid_reg;
    logic                valid_next;
    logic [CMD_BITS-1:0] command_reg;
    logic                level_a_reg;
    logic                level_b_reg;
    logic                take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg <= s_tdata[CMD_BITS-1:0];
            level_a_reg <= s_tdata[CMD_BITS];
            level_b_reg <= s_tdata[CMD_BITS+1];
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.command = command_reg;
    assign stage.level_a = level_a_reg;
    assign stage.level_b = level_b_reg;

endmodule

/* hw/rtl/qedc_core.sv */
// debounce, step decode, counter state and result register
module qedc_core
    import qedc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int TIMER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [WINDOW_BITS-1:0] cfg_wdata,
    input  stage_t                 stage,
    output logic                   advance,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output result_t                result
);

    localparam int CMP_BITS = (TIMER_BITS > WINDOW_BITS) ? TIMER_BITS : WINDOW_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [WINDOW_BITS-1:0]       window_reg;
    logic                         cw_armed_reg;
    logic                         cw_armed_next;
    logic                         ccw_armed_reg;
    logic                         ccw_armed_next;
    logic signed [COUNT_BITS-1:0] step_acc_reg;
    logic signed [COUNT_BITS-1:0] step_acc_next;
    logic                         press_latch_reg;
    logic                         press_latch_next;
    logic [TIMER_BITS-1:0]        quiet_reg;
    logic [TIMER_BITS-1:0]        quiet_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    result_t                      result_reg;
    result_t                      result_next;

    logic                         is_read;
    logic                         fire;
    logic                         edge_ok;
    logic signed [31:0]           acc_wide;
    logic [KEY_BITS-1:0]          key;

    assign is_read = (stage.command == CMD_READ);
    assign advance = !(is_read && m_valid_reg && !m_tready);
    assign fire    = stage.valid && advance;
    assign edge_ok = CMP_BITS'(quiet_reg) >= CMP_BITS'(window_reg);
    assign acc_wide = 32'(step_acc_reg);

    always_comb
    begin
        if (press_latch_reg)
        begin
            key = KEY_ENTER;
        end
        else if (step_acc_reg > 0)
        begin
            key = KEY_NEXT;
        end
        else if (step_acc_reg < 0)
        begin
            key = KEY_PREV;
        end
        else
        begin
            key = KEY_NONE;
        end
    end

    always_comb
    begin
        cw_armed_next    = cw_armed_reg;
        ccw_armed_next   = ccw_armed_reg;
        step_acc_next    = step_acc_reg;
        press_latch_next = press_latch_reg;
        quiet_next       = quiet_reg;
        result_next      = result_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        if (fire)
        begin
            unique case (stage.command)
                CMD_TICK:
                begin
                    if (quiet_reg != TIMER_MAX)
                    begin
                        quiet_next = quiet_reg + 1'b1;
                    end
                end
                CMD_READ:
                begin
                    result_next.step_total = acc_wide[TOTAL_BITS-1:0];
                    result_next.press_seen = press_latch_reg;
                    result_next.nav_key    = key;
                    m_valid_next           = 1'b1;
                    step_acc_next          = '0;
                    press_latch_next       = 1'b0;
                end
                CMD_FALL_A:
                begin
                    if (edge_ok)
                    begin
                        quiet_next = '0;
                        if (!cw_armed_reg && stage.level_b)
                        begin
                            cw_armed_next = 1'b1;
                        end
                        if (ccw_armed_reg && !stage.level_a && !stage.level_b)
                        begin
                            cw_armed_next  = 1'b0;
                            ccw_armed_next = 1'b0;
                            if (step_acc_reg != COUNT_MIN)
                            begin
                                step_acc_next = step_acc_reg - 1'b1;
                            end
                        end
                    end
                end
                CMD_FALL_B:
                begin
                    if (edge_ok)
                    begin
                        quiet_next = '0;
                        if (!ccw_armed_reg && stage.level_a)
                        begin
                            ccw_armed_next = 1'b1;
                        end
                        if (cw_armed_reg && !stage.level_a && !stage.level_b)
                        begin
                            cw_armed_next  = 1'b0;
                            ccw_armed_next = 1'b0;
                            if (step_acc_reg != COUNT_MAX)
                            begin
                                step_acc_next = step_acc_reg + 1'b1;
                            end
                        end
                    end
                end
                CMD_FALL_BTN:
                begin
                    if (edge_ok)
                    begin
                        quiet_next       = '0;
                        press_latch_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= WINDOW_RESET;
            cw_armed_reg    <= 1'b0;
            ccw_armed_reg   <= 1'b0;
            step_acc_reg    <= '0;
            press_latch_reg <= 1'b0;
            quiet_reg       <= TIMER_MAX;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                window_reg <= cfg_wdata;
            end
            cw_armed_reg    <= cw_armed_next;
            ccw_armed_reg   <= ccw_armed_next;
            step_acc_reg    <= step_acc_next;
            press_latch_reg <= press_latch_next;
            quiet_reg       <= quiet_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign result   = result_reg;

endmodule

/* hw/rtl/quadrature_encoder_debounced_counter.sv */
// top level of the debounced quadrature encoder step counter
//
// slave stream carries one event per transfer: a microsecond tick, a
// falling edge on phase a, phase b or the button, or a read request.
// edges closer than the debounce window to the last accepted edge are
// dropped. only a read produces a transfer on the master stream, holding
// the net step count, the button latch and a navigation key; the read
// then clears the count and the latch.
// path: a read accepted on the slave stream passes the input register, then
// the result register, before it shows on the master stream.
// throughput: one event per cycle unless a read is stalled; the state update
// is a single pass through the decode logic between the two registers.
// stall: while a result waits, ticks and edges still flow; a second read
// waits in the input register until the pending result is taken.
// reset: asynchronous active low; window becomes 1000 ticks, flags and
// count clear, quiet time starts saturated so the first edge is accepted.
// cfg_wen/cfg_wdata set the debounce window; the user must write it only while idle, the block does not check this.
module quadrature_encoder_debounced_counter
    import qedc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int TIMER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [WINDOW_BITS-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES_W-1:0]  s_tdata,   // command[2:0], level_a[3], level_b[4]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES_W-1:0] m_tdata    // step_total[15:0], press_seen[16], nav_key[18:17]
);

    stage_t  stage;
    logic    advance;
    result_t result;

    qedc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .stage    (stage)
    );

    qedc_core #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {5'b0, result.nav_key, result.press_seen, result.step_total};

endmodule

/* hw/rtl/qedc_checker.sv */
// port-level checks for the encoder counter, bound to the top level
module qedc_checker
    import qedc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_BYTES_W-1:0] m_tdata
);

    logic [KEY_BITS-1:0]   key;
    logic                  press;
    logic [TOTAL_BITS-1:0] total;

    assign total = m_tdata[TOTAL_BITS-1:0];
    assign press = m_tdata[TOTAL_BITS];
    assign key   = m_tdata[TOTAL_BITS+KEY_BITS:TOTAL_BITS+1];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_enter_press: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (press == (key == KEY_ENTER)))
        else $error("enter key does not match button latch");

    a_zero_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !press && (total == '0) && (COUNT_BITS <= TOTAL_BITS)
        |-> (key == KEY_NONE))
        else $error("zero count with a step key");

    a_sign_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !press && (total != '0) && (COUNT_BITS <= TOTAL_BITS)
        |-> (key == (total[TOTAL_BITS-1] ? KEY_PREV : KEY_NEXT)))
        else $error("step key does not match count sign");

endmodule

bind quadrature_encoder_debounced_counter qedc_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_qedc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
